// File: hw/rtl/lps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg - shared types for the linear prime sieve
// Payload words, command and status codes, and the microprogram of the
// sequencer that runs builds and queries.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LIMIT_W   = 17;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned PVAL_W    = 16;
  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned MAX_NUMBER_DEF  = 65536;
  localparam int unsigned PRIME_SLOTS_DEF = 8192;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // command codes; code 3 has no meaning and reports a range error
  typedef enum logic [CMD_W-1:0] {
    CMD_BUILD = 2'd0,
    CMD_TEST  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                is_prime;
    logic [PVAL_W-1:0]   prime_value;
    logic [COUNT_W-1:0]  prime_count;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_QEMIT,
    OP_INIT,
    OP_CLR,
    OP_WINIT,
    OP_RDI,
    OP_APPEND,
    OP_RDP,
    OP_MUL,
    OP_MARK,
    OP_DIV,
    OP_INCJ,
    OP_INCI,
    OP_BEMIT
  } op_t;

  // jump condition of one microcode step
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_BUILD,
    C_I_NOT_LAST,
    C_J_END,
    C_PROD_GE,
    C_DIV_MORE,
    C_REM_ZERO,
    C_I_MORE
  } cond_t;

  // microprogram addresses
  typedef enum logic [3:0] {
    U_IDLE,
    U_QEMIT,
    U_INIT,
    U_CLR,
    U_WINIT,
    U_WREAD,
    U_APPEND,
    U_JCHK,
    U_MUL,
    U_MARK,
    U_DIV,
    U_TEST,
    U_LOOP,
    U_INCI,
    U_BEMIT
  } upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  wait_in;  // hold here until an input word is taken
    logic  last;     // result step: hold while output is full, then return
  } cw_t;

  function automatic cw_t ucode(input upc_t addr);
    cw_t cw;
    cw = '{op: OP_NOP, cond: C_NEVER, target: U_IDLE, wait_in: 1'b0, last: 1'b0};
    unique case (addr)
      U_IDLE:   cw = '{OP_ACCEPT, C_IN_BUILD,   U_INIT,  1'b1, 1'b0};
      U_QEMIT:  cw = '{OP_QEMIT,  C_NEVER,      U_IDLE,  1'b0, 1'b1};
      U_INIT:   cw = '{OP_INIT,   C_NEVER,      U_IDLE,  1'b0, 1'b0};
      U_CLR:    cw = '{OP_CLR,    C_I_NOT_LAST, U_CLR,   1'b0, 1'b0};
      U_WINIT:  cw = '{OP_WINIT,  C_NEVER,      U_IDLE,  1'b0, 1'b0};
      U_WREAD:  cw = '{OP_RDI,    C_NEVER,      U_IDLE,  1'b0, 1'b0};
      U_APPEND: cw = '{OP_APPEND, C_NEVER,      U_IDLE,  1'b0, 1'b0};
      U_JCHK:   cw = '{OP_RDP,    C_J_END,      U_INCI,  1'b0, 1'b0};
      U_MUL:    cw = '{OP_MUL,    C_NEVER,      U_IDLE,  1'b0, 1'b0};
      U_MARK:   cw = '{OP_MARK,   C_PROD_GE,    U_INCI,  1'b0, 1'b0};
      U_DIV:    cw = '{OP_DIV,    C_DIV_MORE,   U_DIV,   1'b0, 1'b0};
      U_TEST:   cw = '{OP_INCJ,   C_REM_ZERO,   U_INCI,  1'b0, 1'b0};
      U_LOOP:   cw = '{OP_NOP,    C_ALWAYS,     U_JCHK,  1'b0, 1'b0};
      U_INCI:   cw = '{OP_INCI,   C_I_MORE,     U_WREAD, 1'b0, 1'b0};
      U_BEMIT:  cw = '{OP_BEMIT,  C_NEVER,      U_IDLE,  1'b0, 1'b1};
      default:  cw = '{OP_NOP,    C_ALWAYS,     U_IDLE,  1'b0, 1'b0};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/linear_prime_sieve.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_prime_sieve - Euler sieve engine with prime queries
// Usage: write the exclusive upper limit through cfg_we/cfg_wdata while idle
// (a write drops the built state). Send a build word on in_word, then test
// or index words. Each input word gives exactly one result word.
// Input takes a word when in_valid is high and in_stall low; in_stall is low
// only while the sequencer waits at its idle step. Output presents a word
// with out_valid; the word holds while out_stall is high.
// Steps: a test or index query passes the accept step and the result
// step; the result word loads at the result step, which holds on a stall.
// A build accepts, starts and clears the bitmap for limit L, then for each
// number walked reads its bit, appends it if prime and walks the primes;
// a walk stops at the limit or at a divisor. Each mark made runs the
// remainder loop over the W = clog2(MAX_NUMBER) bits, one bit per cycle,
// and the build ends with 1 result step.
// Reset: the sequencer returns to idle, the limit goes to 65536 and the
// sieve counts as not built. A result waiting on a stalled receiver holds
// the sequencer at its result step; no new word is taken meanwhile, since
// in_stall stays high until the sequencer is back at its idle step.
// ----------------------------------------------------------------------------
module linear_prime_sieve #(
  parameter int unsigned MAX_NUMBER  = lps_pkg::MAX_NUMBER_DEF,
  parameter int unsigned PRIME_SLOTS = lps_pkg::PRIME_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lps_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire lps_pkg::in_word_t            in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output lps_pkg::out_word_t                out_word
);

  localparam int unsigned NUM_W   = $clog2(MAX_NUMBER);       // a number below the limit
  localparam int unsigned LIM_W   = $clog2(MAX_NUMBER + 1);   // the limit itself
  localparam int unsigned PIDX_W  = $clog2(PRIME_SLOTS);      // prime list address
  localparam int unsigned CNT_W   = $clog2(PRIME_SLOTS + 1);  // prime count
  localparam int unsigned DCNT_W  = $clog2(NUM_W);            // remainder bit index
  localparam int unsigned PROD_W  = 2 * NUM_W;
  localparam int unsigned COUT_W  = lps_pkg::COUNT_W;
  localparam int unsigned PVAL_W  = lps_pkg::PVAL_W;

  // Storage: composite bitmap and prime list, one write and one registered
  // read port each. Neither is cleared by reset.
  logic              cmap [MAX_NUMBER];
  logic [NUM_W-1:0]  plist [PRIME_SLOTS];

  // Sequencer and configuration
  lps_pkg::upc_t             upc, upc_next;
  lps_pkg::cw_t              cw;
  logic [lps_pkg::LIMIT_W-1:0] sieve_limit;
  logic                      built;
  logic [LIM_W-1:0]          built_lim;
  logic [CNT_W-1:0]          count;

  // Datapath registers
  logic [lps_pkg::CMD_W-1:0] cmd;
  logic [lps_pkg::VALUE_W-1:0] val;
  logic [LIM_W-1:0]          lim;
  logic [LIM_W-1:0]          i;
  logic [CNT_W-1:0]          j;
  logic [NUM_W-1:0]          p;
  logic [PROD_W-1:0]         prod;
  logic [NUM_W-1:0]          rem;
  logic [DCNT_W-1:0]         dcnt;
  logic                      cmap_rd;
  logic [NUM_W-1:0]          plist_rd;

  // Combinational
  logic                      in_fire, out_busy, emit_ok, cond_true;
  logic [LIM_W-1:0]          i_inc, eff_lim;
  logic [NUM_W-1:0]          i_num;
  logic                      prod_ge, append_ok;
  logic [NUM_W:0]            div_sh, div_diff;
  logic                      div_ge;
  logic                      cmap_we, cmap_wdata;
  logic [NUM_W-1:0]          cmap_waddr, cmap_raddr;
  logic                      plist_we;
  logic [PIDX_W-1:0]         plist_waddr, plist_raddr;
  lps_pkg::out_word_t        qres, bres;

  // -- Control word of the current step --------------------------------------
  always_comb begin
    cw       = lps_pkg::ucode(upc);
    in_stall = !cw.wait_in;
    in_fire  = in_valid && cw.wait_in;
    out_busy = out_valid && out_stall;
    emit_ok  = (cw.op == lps_pkg::OP_QEMIT || cw.op == lps_pkg::OP_BEMIT) && !out_busy;
  end

  // -- Datapath helpers ------------------------------------------------------
  always_comb begin
    i_inc     = i + 1'b1;
    i_num     = i[NUM_W-1:0];
    prod_ge   = prod >= PROD_W'(lim);
    append_ok = !cmap_rd && (count < CNT_W'(PRIME_SLOTS));
    // one bit of the restoring remainder i mod p, MSB first
    div_sh    = {rem, i_num[dcnt]};
    div_diff  = div_sh - {1'b0, p};
    div_ge    = div_sh >= {1'b0, p};
  end

  // Saturate the limit register into [3, MAX_NUMBER]
  always_comb begin
    priority if (32'(sieve_limit) < 32'd3) begin
      eff_lim = LIM_W'(3);
    end else if (32'(sieve_limit) > 32'(MAX_NUMBER)) begin
      eff_lim = LIM_W'(MAX_NUMBER);
    end else begin
      eff_lim = LIM_W'(sieve_limit);
    end
  end

  // -- Jump condition and next step ------------------------------------------
  always_comb begin
    unique case (cw.cond)
      lps_pkg::C_NEVER:      cond_true = 1'b0;
      lps_pkg::C_ALWAYS:     cond_true = 1'b1;
      lps_pkg::C_IN_BUILD:   cond_true = in_fire && (in_word.command == lps_pkg::CMD_BUILD);
      lps_pkg::C_I_NOT_LAST: cond_true = i != (lim - 1'b1);
      lps_pkg::C_J_END:      cond_true = j >= count;
      lps_pkg::C_PROD_GE:    cond_true = prod_ge;
      lps_pkg::C_DIV_MORE:   cond_true = dcnt != '0;
      lps_pkg::C_REM_ZERO:   cond_true = rem == '0;
      lps_pkg::C_I_MORE:     cond_true = i_inc < lim;
      default:               cond_true = 1'b0;
    endcase

    priority if (cw.wait_in && !in_fire) begin
      upc_next = upc;
    end else if (cw.last && out_busy) begin
      upc_next = upc;
    end else if (cond_true) begin
      upc_next = cw.target;
    end else if (cw.last) begin
      upc_next = lps_pkg::U_IDLE;
    end else begin
      upc_next = lps_pkg::upc_t'(upc + 4'd1);
    end
  end

  // -- Memory ports ----------------------------------------------------------
  // Clear sweeps the bitmap with the walk counter; marking writes at i*p.
  always_comb begin
    cmap_we    = (cw.op == lps_pkg::OP_CLR) || (cw.op == lps_pkg::OP_MARK && !prod_ge);
    cmap_wdata = cw.op == lps_pkg::OP_MARK;
    cmap_waddr = (cw.op == lps_pkg::OP_CLR) ? i_num : prod[NUM_W-1:0];
    // queries read straight from the incoming word so data is ready next cycle;
    // re-read the same entry while the result step holds
    cmap_raddr = (cw.op == lps_pkg::OP_ACCEPT) ? NUM_W'(in_word.value) :
                 (cw.op == lps_pkg::OP_QEMIT)  ? NUM_W'(val) : i_num;

    plist_we    = (cw.op == lps_pkg::OP_APPEND) && append_ok;
    plist_waddr = count[PIDX_W-1:0];
    plist_raddr = (cw.op == lps_pkg::OP_ACCEPT) ? PIDX_W'(in_word.value) :
                  (cw.op == lps_pkg::OP_QEMIT)  ? PIDX_W'(val) : j[PIDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmap_we) begin
      cmap[cmap_waddr] <= cmap_wdata;
    end
    cmap_rd <= cmap[cmap_raddr];
  end

  always_ff @(posedge clk) begin
    if (plist_we) begin
      plist[plist_waddr] <= i_num;
    end
    plist_rd <= plist[plist_raddr];
  end

  // -- Result words ----------------------------------------------------------
  always_comb begin
    qres             = '0;
    qres.prime_count = built ? COUT_W'(count) : '0;
    priority if (!built && (cmd == lps_pkg::CMD_TEST || cmd == lps_pkg::CMD_READ)) begin
      qres.status = lps_pkg::ST_NOT_BUILT;
    end else if (cmd == lps_pkg::CMD_TEST) begin
      if (32'(val) >= 32'(built_lim)) begin
        qres.status = lps_pkg::ST_RANGE;
      end else begin
        qres.is_prime = (val >= 16'd2) && !cmap_rd;
      end
    end else if (cmd == lps_pkg::CMD_READ) begin
      if (32'(val) >= 32'(count)) begin
        qres.status = lps_pkg::ST_RANGE;
      end else begin
        qres.prime_value = PVAL_W'(plist_rd);
      end
    end else begin
      // unknown command
      qres.status = lps_pkg::ST_RANGE;
    end

    bres             = '0;
    bres.prime_count = COUT_W'(count);
    bres.status      = lps_pkg::ST_OK;
  end

  // -- Sequencer, control state and datapath registers -----------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      upc         <= lps_pkg::U_IDLE;
      sieve_limit <= lps_pkg::LIMIT_RESET;
      built       <= 1'b0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      upc <= upc_next;

      // output register: load a result, drop it once taken
      if (emit_ok) begin
        out_valid <= 1'b1;
        out_word  <= (cw.op == lps_pkg::OP_BEMIT) ? bres : qres;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (cw.op)
        lps_pkg::OP_ACCEPT: begin
          if (in_fire) begin
            cmd <= in_word.command;
            val <= in_word.value;
          end
        end
        lps_pkg::OP_INIT: begin
          lim   <= eff_lim;
          count <= '0;
          i     <= '0;
        end
        lps_pkg::OP_CLR: begin
          i <= i_inc;
        end
        lps_pkg::OP_WINIT: begin
          i <= LIM_W'(2);
        end
        lps_pkg::OP_RDI: begin
          j <= '0;
        end
        lps_pkg::OP_APPEND: begin
          if (append_ok) begin
            count <= count + 1'b1;
          end
        end
        lps_pkg::OP_MUL: begin
          p    <= plist_rd;
          prod <= PROD_W'(i_num) * PROD_W'(plist_rd);
        end
        lps_pkg::OP_MARK: begin
          // arm the remainder loop; it only matters when the mark was made
          rem  <= '0;
          dcnt <= DCNT_W'(NUM_W - 1);
        end
        lps_pkg::OP_DIV: begin
          rem  <= div_ge ? div_diff[NUM_W-1:0] : div_sh[NUM_W-1:0];
          dcnt <= dcnt - 1'b1;
        end
        lps_pkg::OP_INCJ: begin
          j <= j + 1'b1;
        end
        lps_pkg::OP_INCI: begin
          i <= i_inc;
        end
        lps_pkg::OP_BEMIT: begin
          if (!out_busy) begin
            built     <= 1'b1;
            built_lim <= lim;
          end
        end
        default: begin
          // no datapath change
        end
      endcase

      // a new limit invalidates the sieve
      if (cfg_we) begin
        sieve_limit <= cfg_wdata;
        built       <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
